// ===== rtl/core/asu_pkg.sv =====
// shared types and defaults for the ascending integer sorter
`timescale 1ns / 1ps

package asu_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // fill: beats enter the chain; drain: sorted beats leave from the head
    typedef enum logic
    {
        ST_FILL  = 1'b0,
        ST_DRAIN = 1'b1
    } asu_state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed
    {
        logic insert;
        logic shift;
    } asu_cell_ctl_t;

endpackage

// ===== rtl/core/asu_cell.sv =====
// one cell of the insertion chain: holds one value and its valid flag
`timescale 1ns / 1ps

module asu_cell
    import asu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  asu_cell_ctl_t         ctl,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic                  prev_valid,
    input  logic                  prev_gt,
    input  logic [VALUE_BITS-1:0] next_value,
    input  logic                  next_valid,
    output logic [VALUE_BITS-1:0] value,
    output logic                  valid,
    output logic                  gt
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;

    // empty cells count as larger than anything, so the chain stays packed
    assign gt = !valid_reg || ($signed(value_reg) > $signed(new_value));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctl.insert && gt)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/core/ascending_integer_sorter_unit.sv =====
// top level of the ascending integer sorter: insertion chain plus fill/drain control
`timescale 1ns / 1ps

// fill: one beat accepted per cycle, sorted into the chain as it arrives unless the chain is full
// drain: after the beat flagged last_in, one sorted beat per cycle on strobe,
//   starting the cycle after that beat, n beats for a batch of n stored values
// busy is high for the whole drain; the receiver cannot stall the drain
// asynchronous active-low reset empties the chain and clears the overflow flag

module ascending_integer_sorter_unit
    import asu_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last_in,
    output logic                  strobe,
    output logic [VALUE_BITS-1:0] sorted_value,
    output logic                  last_out,
    output logic                  overflow
);

    asu_state_t    state_reg;
    asu_state_t    state_next;
    logic          overflow_reg;
    logic          overflow_next;
    asu_cell_ctl_t cell_ctl;

    // chain taps, cell 0 holds the smallest value
    logic [VALUE_BITS-1:0] cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  cell_valid;
    logic [MAX_ITEMS-1:0]  cell_gt;

    logic accept;
    logic chain_full;
    logic final_beat;

    assign accept     = start && (state_reg == ST_FILL);
    // the tail cell only fills once every cell ahead of it is occupied
    assign chain_full = cell_valid[MAX_ITEMS-1];
    // the head is the final beat when nothing stands behind it
    assign final_beat = !cell_valid[1];

    // next state
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (chain_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (final_beat)
                begin
                    state_next    = ST_FILL;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // outputs and chain commands
    always_comb
    begin
        cell_ctl.insert = 1'b0;
        cell_ctl.shift  = 1'b0;
        busy            = 1'b0;
        strobe          = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                // a beat arriving at a full chain is dropped
                cell_ctl.insert = accept && !chain_full;
            end
            ST_DRAIN:
            begin
                busy           = 1'b1;
                strobe         = 1'b1;
                cell_ctl.shift = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign sorted_value = cell_value[0];
    assign last_out     = strobe && final_beat;
    assign overflow     = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // the cell chain; each cell sees the incoming beat and its two neighbours
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] prev_value;
        logic                  prev_valid;
        logic                  prev_gt;
        logic [VALUE_BITS-1:0] next_value;
        logic                  next_valid;

        if (i == 0)
        begin : g_head
            // nothing ahead of the head: an insertion here takes the new beat
            assign prev_value = value;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            // draining pulls an empty slot into the tail
            assign next_value = value;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        asu_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .new_value  (value),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the ascending integer sorter: directed and random batches
`timescale 1ns / 1ps

module tb_top
    import asu_pkg::*;
();

    // one sorted beat as the block should present it
    typedef struct {
        logic [VALUE_BITS_DEF-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } sorted_beat_t;

    // tracks the batch being collected and the sorted beats still owed by the block
    class sort_scoreboard;
        logic signed [VALUE_BITS_DEF-1:0] batch_store [MAX_ITEMS_DEF];
        int unsigned                      batch_fill;
        bit                               batch_dropped;
        sorted_beat_t                     sorted_due [$];
        int unsigned                      mismatches;

        function new();
            batch_fill    = 0;
            batch_dropped = 1'b0;
            mismatches    = 0;
        endfunction

        // an accepted input beat: store or drop it, and on the closing beat sort the batch
        function void note_beat(input logic [VALUE_BITS_DEF-1:0] v, input logic lst);
            logic signed [VALUE_BITS_DEF-1:0] cur;
            sorted_beat_t                     b;
            int                               i;
            int                               j;
            if (batch_fill < MAX_ITEMS_DEF)
            begin
                batch_store[batch_fill] = v;
                batch_fill++;
            end
            else
            begin
                batch_dropped = 1'b1;
            end
            if (lst)
            begin
                for (i = 1; i < batch_fill; i++)
                begin
                    cur = batch_store[i];
                    j   = i;
                    while (j > 0 && batch_store[j-1] > cur)
                    begin
                        batch_store[j] = batch_store[j-1];
                        j--;
                    end
                    batch_store[j] = cur;
                end
                for (i = 0; i < batch_fill; i++)
                begin
                    b.sorted_value = batch_store[i];
                    b.last_out     = (i == batch_fill - 1);
                    b.overflow     = batch_dropped;
                    sorted_due.push_back(b);
                end
                batch_fill    = 0;
                batch_dropped = 1'b0;
            end
        endfunction

        // a sorted beat seen on the outputs: compare it with the oldest one owed
        function void check_beat(input logic [VALUE_BITS_DEF-1:0] v, input logic lst,
                                 input logic ovf);
            sorted_beat_t b;
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected sorted beat, expected none, actual %0d",
                         $time, $signed(v));
                mismatches++;
                return;
            end
            b = sorted_due.pop_front();
            if (b.sorted_value !== v)
            begin
                $display("%0t: sorted_value expected %0d actual %0d",
                         $time, $signed(b.sorted_value), $signed(v));
                mismatches++;
            end
            if (b.last_out !== lst)
            begin
                $display("%0t: last_out expected %0b actual %0b", $time, b.last_out, lst);
                mismatches++;
            end
            if (b.overflow !== ovf)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, b.overflow, ovf);
                mismatches++;
            end
        endfunction

        function int unsigned beats_owed();
            return sorted_due.size();
        endfunction
    endclass

    localparam int VBITS        = VALUE_BITS_DEF;
    localparam int CAPACITY     = MAX_ITEMS_DEF;
    // least items per random phase; with the directed batches, at least 343 beats in all
    localparam int PHASE_ITEMS  = 80;
    // cycles with neither an accepted beat nor a strobe before the run is abandoned
    localparam int STALL_LIMIT  = 1000;
    // settling cycles after the last owed beat has arrived
    localparam int TAIL_CYCLES  = 8;

    localparam logic [VBITS-1:0] VAL_MIN = {1'b1, {(VBITS-1){1'b0}}};
    localparam logic [VBITS-1:0] VAL_MAX = {1'b0, {(VBITS-1){1'b1}}};

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [VBITS-1:0] value;
    logic             last_in;
    logic             strobe;
    logic [VBITS-1:0] sorted_value;
    logic             last_out;
    logic             overflow;

    sort_scoreboard   sorter_sb;
    // percentage of cycles in which the sender holds start low
    int               idle_pct;

    ascending_integer_sorter_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_in      (last_in),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitor: sampled at the rising edge, so it sees the values the block saw
    // an input beat is taken when start is high and busy is low
    // a sorted beat is taken whenever strobe is high; the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sorter_sb.note_beat(value, last_in);
        if (rst_n && strobe)
            sorter_sb.check_beat(sorted_value, last_out, overflow);
    end

    // watchdog: counts cycles with no traffic in either direction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // offer one beat: optional idle cycles first, then hold start until busy is low
    // inputs change at the falling edge only; noise is driven while start is low
    task automatic send_beat(input logic [VBITS-1:0] v, input logic lst);
        logic taken;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                @(negedge clk);
                start   <= 1'b0;
                value   <= $urandom;
                last_in <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
            @(negedge clk);
            start   <= 1'b1;
            value   <= v;
            last_in <= lst;
            taken = 1'b0;
            while (!taken)
            begin
                @(posedge clk);
                // busy as the block saw it at this edge
                taken = !busy;
            end
        end
    endtask

    // one random batch of the given length; values mix full-range, near zero,
    // the extremes and repeats of the previous value so that ties are common
    task automatic send_random_batch(input int len, inout int sent,
                                     inout logic [VBITS-1:0] prev);
        logic [VBITS-1:0] v;
        int               i;
        int               pick;
        begin
            for (i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    v = $urandom;
                else if (pick < 6)
                    v = $urandom_range(0, 8) - 4;
                else if (pick == 6)
                begin
                    case ($urandom_range(0, 3))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        2:       v = '0;
                        default: v = '1;
                    endcase
                end
                else
                    v = prev;
                prev = v;
                send_beat(v, i == len - 1);
                sent++;
            end
        end
    endtask

    // directed batches: single extremes, a mix of extremes and bit patterns,
    // ties, an already ascending batch and a descending one
    logic [VBITS-1:0] dir_vals [23] = '{
        VAL_MIN,
        VAL_MAX,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, VAL_MAX, VAL_MIN,
        32'hAAAA_AAAA, 32'h5555_5555,
        32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005, 32'hFFFF_FFFB,
        32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0064, 32'h0000_0032, 32'h0000_0000, 32'hFFFF_FFCE, 32'hFFFF_FF9C
    };
    int dir_lens [6] = '{1, 1, 7, 5, 4, 5};

    // phase plan: no idling, heavy sender idling, light idling, no idling again
    int phase_idle [4] = '{0, 70, 13, 0};

    initial
    begin : stimulus
        int               b;
        int               k;
        int               pos;
        int               ph;
        int               sent;
        int               len;
        logic [VBITS-1:0] prev;

        sorter_sb = new();
        idle_pct  = 0;
        start     = 1'b0;
        value     = '0;
        last_in   = 1'b0;
        rst_n     = 1'b0;
        prev      = '0;

        // reset held low from time zero, released at a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        pos = 0;
        for (b = 0; b < 6; b++)
        begin
            for (k = 0; k < dir_lens[b]; k++)
            begin
                send_beat(dir_vals[pos], k == dir_lens[b] - 1);
                pos++;
            end
        end

        for (ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            sent     = 0;
            // a full batch with no drop, then a batch whose tail is dropped
            // (closing beat included), then random batches mostly short
            if (ph == 0)
                send_random_batch(CAPACITY, sent, prev);
            else if (ph == 1)
                send_random_batch(CAPACITY + 3, sent, prev);
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
                else
                    len = $urandom_range(1, 12);
                send_random_batch(len, sent, prev);
            end
        end

        @(negedge clk);
        start   <= 1'b0;
        last_in <= 1'b0;

        // drain whatever is still owed, then idle for the settling period
        while (sorter_sb.beats_owed() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sorter_sb.mismatches == 0 && sorter_sb.beats_owed() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/asu_pkg.sv
rtl/core/asu_cell.sv
rtl/core/ascending_integer_sorter_unit.sv
bench/tb_top.sv
